### rtl/tsfb_pkg.sv
// ----------------------------------------------------------------------------
// tsfb_pkg
// Shared types and header constants for the TCP SYN frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfb_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_SOURCE_MAC  = 8'd0;
  localparam logic [7:0] REG_TARGET_MAC  = 8'd1;
  localparam logic [7:0] REG_SOURCE_IPV4 = 8'd2;
  localparam logic [7:0] REG_DEST_IPV4   = 8'd3;

  // Fixed header fields
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TOS         = 8'd16;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
  localparam logic [15:0] IP_ID          = 16'd10201;
  localparam logic [15:0] IP_FLAGS_FRAG  = 16'h4000;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam logic [15:0] TCP_SEG_LEN    = 16'd20;
  localparam logic [7:0]  TCP_DATA_OFS   = 8'h50;
  localparam logic [7:0]  TCP_FLAGS_SYN  = 8'h02;
  localparam logic [15:0] TCP_WINDOW     = 16'd5840;

  // Bytes of header ahead of the zero padding
  localparam int HDR_BYTES = 54;

  // Constant words of the IPv4 header sum (checksum word taken as zero)
  localparam logic [15:0] IP_CONST_SUM = 16'({IP_VER_IHL, IP_TOS} + IP_TOTAL_LEN
                                            + IP_ID + IP_FLAGS_FRAG
                                            + {IP_TTL, IP_PROTO_TCP});

  // Constant words of pseudoheader plus TCP header
  localparam logic [15:0] TCP_CONST_SUM = 16'({8'd0, IP_PROTO_TCP} + TCP_SEG_LEN
                                             + {TCP_DATA_OFS, TCP_FLAGS_SYN}
                                             + TCP_WINDOW);

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] target_mac;
    logic [31:0] source_ipv4;
    logic [31:0] dest_ipv4;
  } tsfb_cfg_t;

  typedef struct packed {
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tsfb_hdr_t;

endpackage

`default_nettype wire

### rtl/tsfb_csum.sv
// ----------------------------------------------------------------------------
// tsfb_csum
// Four-stage pipeline computing the IPv4 header and TCP checksums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfb_csum
  import tsfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tsfb_cfg_t cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [15:0] from_port,
  input  wire logic [15:0] to_port,
  output logic           hdr_valid,
  input  wire logic      hdr_ready,
  output tsfb_hdr_t      hdr
);

  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;

  logic [17:0] addr_sum;
  logic [16:0] port_sum;
  logic [15:0] sp1, dp1, sp2, dp2, sp3, dp3;
  logic [18:0] ip_raw, tcp_raw;
  logic [16:0] ip_f1, tcp_f1;

  assign rdy4     = !v4 || hdr_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: address words and port words
  always_ff @(posedge clk) begin
    if (rdy1) begin
      addr_sum <= 18'(cfg.source_ipv4[31:16]) + 18'(cfg.source_ipv4[15:0])
                + 18'(cfg.dest_ipv4[31:16]) + 18'(cfg.dest_ipv4[15:0]);
      port_sum <= 17'(from_port) + 17'(to_port);
      sp1      <= from_port;
      dp1      <= to_port;
    end
  end

  // Stage 2: add the fixed words
  always_ff @(posedge clk) begin
    if (rdy2) begin
      ip_raw  <= 19'(addr_sum) + 19'(IP_CONST_SUM);
      tcp_raw <= 19'(addr_sum) + 19'(port_sum) + 19'(TCP_CONST_SUM);
      sp2     <= sp1;
      dp2     <= dp1;
    end
  end

  // Stage 3: first end-around carry fold
  always_ff @(posedge clk) begin
    if (rdy3) begin
      ip_f1  <= 17'(ip_raw[15:0]) + 17'(ip_raw[18:16]);
      tcp_f1 <= 17'(tcp_raw[15:0]) + 17'(tcp_raw[18:16]);
      sp3    <= sp2;
      dp3    <= dp2;
    end
  end

  // Stage 4: second fold cannot carry again; complement
  always_ff @(posedge clk) begin
    if (rdy4) begin
      hdr.ip_csum   <= ~(ip_f1[15:0] + 16'(ip_f1[16]));
      hdr.tcp_csum  <= ~(tcp_f1[15:0] + 16'(tcp_f1[16]));
      hdr.from_port <= sp3;
      hdr.to_port   <= dp3;
    end
  end

  assign hdr_valid = v4;

endmodule

`default_nettype wire

### rtl/tsfb_ser.sv
// ----------------------------------------------------------------------------
// tsfb_ser
// Frame serializer: one byte per beat from a held header, then zero padding.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfb_ser
  import tsfb_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tsfb_cfg_t cfg,
  input  wire logic      hdr_valid,
  output logic           hdr_ready,
  input  wire tsfb_hdr_t hdr,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);

  localparam int CW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] HDR_END  = CW'(HDR_BYTES);

  logic            busy;
  logic [CW-1:0]   cnt;
  tsfb_hdr_t       cur;
  logic            out_free;
  logic            emit;
  logic            at_last;
  logic [HDR_BYTES*8-1:0] hdr_vec;
  logic [7:0]      hdr_bytes [HDR_BYTES];
  logic [7:0]      byte_sel;

  assign out_free  = !m_tvalid || m_tready;
  assign emit      = busy && out_free;
  assign at_last   = (cnt == LAST_IDX);
  assign hdr_ready = !busy || (emit && at_last);

  assign hdr_vec = {cfg.target_mac, cfg.source_mac, ETHERTYPE_IPV4,
                    IP_VER_IHL, IP_TOS, IP_TOTAL_LEN, IP_ID, IP_FLAGS_FRAG,
                    IP_TTL, IP_PROTO_TCP, cur.ip_csum,
                    cfg.source_ipv4, cfg.dest_ipv4,
                    cur.from_port, cur.to_port, 32'd0, 32'd0,
                    TCP_DATA_OFS, TCP_FLAGS_SYN, TCP_WINDOW, cur.tcp_csum, 16'd0};

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_bytes[i] = hdr_vec[(HDR_BYTES-1-i)*8 +: 8];
    end
    if (cnt < HDR_END) begin
      byte_sel = hdr_bytes[cnt];
    end else begin
      byte_sel = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // take the next header, possibly on the last beat of the current frame
      if (hdr_valid && hdr_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        busy <= !at_last;
        cnt  <= at_last ? '0 : cnt + 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && hdr_ready) cur <= hdr;
    if (emit) begin
      m_tdata <= byte_sel;
      m_tlast <= at_last;
    end
  end

endmodule

`default_nettype wire

### rtl/tcp_syn_frame_builder.sv
// ----------------------------------------------------------------------------
// tcp_syn_frame_builder
// Builds an Ethernet II / IPv4 / TCP SYN frame for each port pair received.
// ----------------------------------------------------------------------------
// Each input beat carries a TCP source and destination port; the block answers
// with FRAME_BYTES output beats, one frame byte each in wire order, tlast on
// the final one. MAC and IPv4 addresses come from the configuration registers
// (0 source MAC, 1 target MAC, 2 source IPv4, 3 dest IPv4; other indexes are
// ignored). Both checksums are computed in a four-stage pipeline, after which the
// serializer takes the header and registers one frame byte per beat out, stalling
// while m_tready is low; up to four further port pairs queue in the pipeline
// meanwhile. Write configuration only while no frame is pending.
`default_nettype none

module tcp_syn_frame_builder
  import tsfb_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] from_port, [31:16] to_port
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] frame_byte
  output logic             m_tlast
);

  tsfb_cfg_t cfg;
  tsfb_hdr_t hdr;
  logic      hdr_valid;
  logic      hdr_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_MAC:  cfg.source_mac  <= cfg_data;
        REG_TARGET_MAC:  cfg.target_mac  <= cfg_data;
        REG_SOURCE_IPV4: cfg.source_ipv4 <= cfg_data[31:0];
        REG_DEST_IPV4:   cfg.dest_ipv4   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  tsfb_csum u_csum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .from_port (s_tdata[15:0]),
    .to_port   (s_tdata[31:16]),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr)
  );

  tsfb_ser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

### sim/tcp_syn_frame_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_frame_builder_tb
// Self-checking bench for the TCP SYN frame builder.
// ----------------------------------------------------------------------------
// Port pairs stream in with random gaps while the output side stalls at
// random. Each accepted pair is expanded into its 64 expected frame bytes by a
// local frame model: MAC and IPv4 addresses, fixed header fields, both
// checksums and the zero padding. Output beats are then compared byte by byte,
// together with tlast. The address registers are rewritten between phases,
// all-zero and all-one values included. One phase backs up the output for a
// long stretch so that the input side has to stall.
// ----------------------------------------------------------------------------

module tcp_syn_frame_builder_tb;
  import tsfb_pkg::*;

  localparam int FRAME_LEN    = 64;
  localparam int CHOKE_CYCLES = 400;
  // Output beats keep landing during even a slow frame; the longest quiet
  // stretch is the output hold-off.
  localparam int STALL_LIMIT  = 3000;
  localparam logic [7:0] REG_UNUSED_LO = 8'd4;
  localparam logic [7:0] REG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic [15:0] to_port;
    logic [15:0] from_port;
  } port_pair_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    int         ofs;
  } frame_byte_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [47:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  tsfb_cfg_t   addr_regs = '0;
  port_pair_t  port_q[$];
  frame_byte_t syn_bytes_q[$];

  logic s_beat = 1'b0;
  logic m_beat = 1'b0;
  logic choke_req = 1'b0;
  int   in_idle_max  = 6;
  int   out_idle_max = 6;
  int   pair_gap     = 0;
  int   byte_gap     = 0;
  int   choke_left   = 0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;
  int   pairs_taken  = 0;
  int   bytes_checked = 0;
  int   reg_writes   = 0;

  tcp_syn_frame_builder #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One's complement fold of a 32-bit word sum, then complement.
  function automatic logic [15:0] fold_complement(input logic [31:0] acc);
    while (acc[31:16] != 16'd0)
      acc = acc[31:16] + acc[15:0];
    return ~acc[15:0];
  endfunction

  // Pseudoheader plus the constant TCP words; ports are added on top.
  function automatic logic [31:0] tcp_base_sum(input tsfb_cfg_t c);
    return c.source_ipv4[31:16] + c.source_ipv4[15:0] + c.dest_ipv4[31:16]
         + c.dest_ipv4[15:0] + IP_PROTO_TCP + TCP_SEG_LEN
         + {TCP_DATA_OFS, TCP_FLAGS_SYN} + TCP_WINDOW;
  endfunction

  task automatic build_syn_frame(input logic [15:0] sport, input logic [15:0] dport);
    logic [7:0]  fb [FRAME_LEN];
    logic [31:0] acc;
    for (int i = 0; i < FRAME_LEN; i++)
      fb[i] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      fb[i]     = addr_regs.target_mac[47 - 8 * i -: 8];
      fb[6 + i] = addr_regs.source_mac[47 - 8 * i -: 8];
    end
    {fb[12], fb[13]} = ETHERTYPE_IPV4;
    fb[14] = IP_VER_IHL;
    fb[15] = IP_TOS;
    {fb[16], fb[17]} = IP_TOTAL_LEN;
    {fb[18], fb[19]} = IP_ID;
    {fb[20], fb[21]} = IP_FLAGS_FRAG;
    fb[22] = IP_TTL;
    fb[23] = IP_PROTO_TCP;
    {fb[26], fb[27], fb[28], fb[29]} = addr_regs.source_ipv4;
    {fb[30], fb[31], fb[32], fb[33]} = addr_regs.dest_ipv4;
    acc = '0;
    for (int i = 14; i < 34; i += 2)
      acc += {fb[i], fb[i + 1]};
    {fb[24], fb[25]} = fold_complement(acc);
    {fb[34], fb[35]} = sport;
    {fb[36], fb[37]} = dport;
    fb[46] = TCP_DATA_OFS;
    fb[47] = TCP_FLAGS_SYN;
    {fb[48], fb[49]} = TCP_WINDOW;
    {fb[50], fb[51]} = fold_complement(tcp_base_sum(addr_regs) + sport + dport);
    for (int i = 0; i < FRAME_LEN; i++)
      syn_bytes_q.push_back('{value: fb[i], last: (i == FRAME_LEN - 1), ofs: i});
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Sample all handshakes, track the registers, predict and check.
  always @(posedge clk) begin
    frame_byte_t want;
    s_beat <= !rst && s_tvalid && s_tready;
    m_beat <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_SOURCE_MAC:  addr_regs.source_mac  = cfg_data;
          REG_TARGET_MAC:  addr_regs.target_mac  = cfg_data;
          REG_SOURCE_IPV4: addr_regs.source_ipv4 = cfg_data[31:0];
          REG_DEST_IPV4:   addr_regs.dest_ipv4   = cfg_data[31:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pairs_taken++;
        build_syn_frame(s_tdata[15:0], s_tdata[31:16]);
      end
      if (m_tvalid && m_tready) begin
        if (syn_bytes_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h with no frame pending", m_tdata));
        end else begin
          want = syn_bytes_q.pop_front();
          bytes_checked++;
          if (m_tdata !== want.value)
            report_mismatch($sformatf("byte %0d: data %02h, want %02h",
                                      want.ofs, m_tdata, want.value));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("byte %0d: tlast %b, want %b",
                                      want.ofs, m_tlast, want.last));
        end
      end
    end
  end

  // Port pair driver: draw a gap after every accepted beat.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      pair_gap = 0;
    end else begin
      if (s_beat)
        pair_gap = $urandom_range(in_idle_max);
      if (!s_tvalid || s_beat) begin
        if (pair_gap != 0) begin
          pair_gap--;
          s_tvalid <= 1'b0;
        end else if (port_q.size() != 0) begin
          s_tdata  <= port_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Frame receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      byte_gap = 0;
      choke_left = 0;
    end else begin
      if (choke_req) begin
        choke_left = CHOKE_CYCLES;
        choke_req = 1'b0;
      end
      if (m_beat)
        byte_gap = $urandom_range(out_idle_max);
      if (choke_left != 0) begin
        choke_left--;
        m_tready <= 1'b0;
      end else if (byte_gap != 0) begin
        byte_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] pick_addr();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic reload_addresses();
    write_reg(REG_SOURCE_MAC,  pick_addr());
    write_reg(REG_TARGET_MAC,  pick_addr());
    write_reg(REG_SOURCE_IPV4, pick_addr());
    write_reg(REG_DEST_IPV4,   pick_addr());
    @(posedge clk);
  endtask

  task automatic send_pair(input logic [15:0] from_p, input logic [15:0] to_p);
    port_q.push_back({to_p, from_p});
  endtask

  // Hold until every pair is out and every frame byte has come back.
  task automatic wait_idle();
    while (port_q.size() != 0 || s_tvalid || syn_bytes_q.size() != 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    logic [15:0] zero_csum_port;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at their reset value: all-zero addresses.
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h0050, 16'h01BB);
    send_pair(16'h8000, 16'h0001);
    wait_idle();

    // All-one addresses; the IPv4 registers must drop the upper data bits.
    // Writes to unmapped indexes must leave everything alone.
    write_reg(REG_SOURCE_MAC,  '1);
    write_reg(REG_TARGET_MAC,  '1);
    write_reg(REG_SOURCE_IPV4, '1);
    write_reg(REG_DEST_IPV4,   '1);
    write_reg(REG_UNUSED_LO,   48'({$urandom, $urandom}));
    write_reg(REG_UNUSED_HI,   48'({$urandom, $urandom}));
    @(posedge clk);
    // Source port that makes the TCP sum fold to all ones: checksum zero.
    zero_csum_port = fold_complement(tcp_base_sum(addr_regs));
    send_pair(zero_csum_port, 16'h0000);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0001, 16'hFFFE);
    send_pair(16'h1234, 16'h4321);
    wait_idle();

    // Back up the output so the pipeline fills and the input stalls.
    reload_addresses();
    in_idle_max = 0;
    choke_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_pair(rand_port(), rand_port());
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      reload_addresses();
      case (ph % 3)
        0: begin in_idle_max = 6; out_idle_max = 6; end
        1: begin in_idle_max = 0; out_idle_max = 0; end
        default: begin in_idle_max = 6; out_idle_max = 0; end
      endcase
      for (int i = 0; i < 70; i++)
        send_pair(rand_port(), rand_port());
      wait_idle();
    end

    $display("%0d port pairs framed under %0d register writes, %0d frame bytes compared",
             pairs_taken, reg_writes, bytes_checked);
    $display("exercised: reset, all-one and random addresses, one long output stall");
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
